[rtl/rti_pkg.sv]
`default_nettype none

package rti_pkg;

  // Fixed formats of the transaction fields.
  localparam int COORD_W       = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int EPS_W         = 17;
  localparam logic [EPS_W-1:0] EPS_RESET = 17'd1;
  localparam int DIST_W        = 31;
  localparam int REASON_W      = 3;

  // Internal widths of the exact arithmetic.
  localparam int SUB_W   = COORD_W + 1;
  localparam int CROSS_W = 2 * COORD_W + 2;
  localparam int DOT_W   = 3 * COORD_W + 5;
  localparam int EXT_W   = DOT_W + 32;
  localparam int META_W  = REASON_W + 1;

  // Multiplier slicing and pipeline depth.
  localparam int MUL_CHUNK = 32;
  localparam int MUL_LAT   = 4;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [REASON_W-1:0] {
    RSN_HIT      = 3'd0,
    RSN_PARALLEL = 3'd1,
    RSN_U_RANGE  = 3'd2,
    RSN_V_RANGE  = 3'd3,
    RSN_BEHIND   = 3'd4
  } reason_t;

  typedef struct packed {
    logic                      opcode;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic signed [COORD_W-1:0] third_x;
    logic signed [COORD_W-1:0] third_y;
    logic signed [COORD_W-1:0] third_z;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic [DIST_W-1:0]   distance;
    logic [REASON_W-1:0] miss_reason;
  } out_item_t;

  // One triangle test as it waits in the queue.
  typedef struct packed {
    logic [2:0][COORD_W-1:0] d;
    logic [2:0][COORD_W-1:0] e1;
    logic [2:0][COORD_W-1:0] e2;
    logic [2:0][SUB_W-1:0]   s;
  } job_t;

endpackage

`default_nettype wire

[rtl/rti_mul.sv]
`default_nettype none

module rti_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0]   p
);
  import rti_pkg::*;

  localparam int CH = MUL_CHUNK;
  localparam int NA = (AW + CH - 1) / CH;
  localparam int NB = (BW + CH - 1) / CH;
  localparam int SW = (NA + NB) * CH;

  logic [AW-1:0]    a_abs;
  logic [BW-1:0]    b_abs;
  logic [NA*CH-1:0] mag_a;
  logic [NB*CH-1:0] mag_b;
  logic             neg1;
  logic [2*CH-1:0]  pp [NA][NB];
  logic             neg2;
  logic [SW-1:0]    sum_c;
  logic [SW-1:0]    sum;
  logic             neg3;

  // Work on magnitudes so that every partial product is unsigned.
  always_comb begin
    a_abs = a[AW-1] ? AW'(-a) : AW'(a);
    b_abs = b[BW-1] ? BW'(-b) : BW'(b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a <= (NA*CH)'(a_abs);
      mag_b <= (NB*CH)'(b_abs);
      neg1  <= a[AW-1] ^ b[BW-1];
    end
  end

  // One chunk-by-chunk product per register.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= mag_a[i*CH +: CH] * mag_b[j*CH +: CH];
        end
      end
      neg2 <= neg1;
    end
  end

  // Add the aligned partial products.
  always_comb begin
    sum_c = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_c = sum_c + (SW'(pp[i][j]) << (CH * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum  <= sum_c;
      neg3 <= neg2;
    end
  end

  // Restore the sign.
  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg3 ? -$signed((AW+BW)'(sum)) : $signed((AW+BW)'(sum));
    end
  end

endmodule

`default_nettype wire

[rtl/rti_div.sv]
`default_nettype none

module rti_div #(
  parameter int NW = 133,
  parameter int DW = 101,
  parameter int QW = 31,
  parameter int MW = 4
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [MW-1:0] meta_in,
  output logic [QW-1:0]      quo,
  output logic [MW-1:0]      meta_out
);
  import rti_pkg::*;

  logic [NW-1:0] rem  [QW];
  logic [DW-1:0] dv   [QW];
  logic [QW-1:0] q    [QW];
  logic [MW-1:0] meta [QW];

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [NW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [MW-1:0] m_in;
    logic [NW-1:0] part;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
      assign m_in = meta_in;
    end else begin : g_next
      assign r_in = rem[k-1];
      assign d_in = dv[k-1];
      assign q_in = q[k-1];
      assign m_in = meta[k-1];
    end

    assign part = NW'(d_in) << B;
    assign ge   = (r_in >= part);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? r_in - part : r_in;
        dv[k]   <= d_in;
        q[k]    <= q_in | (QW'(ge) << B);
        meta[k] <= m_in;
      end
    end
  end

  assign quo      = q[QW-1];
  assign meta_out = meta[QW-1];

endmodule

`default_nettype wire

[rtl/rti_front.sv]
`default_nettype none

module rti_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire rti_pkg::in_item_t req,
  input  wire logic              pop,
  output rti_pkg::job_t          job,
  output logic                   job_valid
);
  import rti_pkg::*;

  localparam int QP = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [COORD_W-1:0] origin [3];
  logic [COORD_W-1:0] dir    [3];
  job_t               mem    [QUEUE_DEPTH];
  logic [QP-1:0]      wr_ptr;
  logic [QP-1:0]      rd_ptr;
  logic [CW-1:0]      count;
  logic               accept;
  logic               push;
  job_t               job_in;

  assign req_ready = (count != CW'(QUEUE_DEPTH));
  assign job_valid = (count != '0);
  assign accept    = req_valid && req_ready;
  assign push      = accept && (req.opcode == OP_TEST);

  // A ray load replaces the stored ray and produces no result.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        origin[i] <= '0;
        dir[i]    <= '0;
      end
    end else if (accept && (req.opcode == OP_LOAD)) begin
      origin[0] <= req.first_x;
      origin[1] <= req.first_y;
      origin[2] <= req.first_z;
      dir[0]    <= req.second_x;
      dir[1]    <= req.second_y;
      dir[2]    <= req.second_z;
    end
  end

  // A test carries the current ray and the offset from v0 to the origin.
  always_comb begin
    job_in.d[0]  = dir[0];
    job_in.d[1]  = dir[1];
    job_in.d[2]  = dir[2];
    job_in.e1[0] = req.second_x;
    job_in.e1[1] = req.second_y;
    job_in.e1[2] = req.second_z;
    job_in.e2[0] = req.third_x;
    job_in.e2[1] = req.third_y;
    job_in.e2[2] = req.third_z;
    job_in.s[0]  = SUB_W'($signed(origin[0])) - SUB_W'(req.first_x);
    job_in.s[1]  = SUB_W'($signed(origin[1])) - SUB_W'(req.first_y);
    job_in.s[2]  = SUB_W'($signed(origin[2])) - SUB_W'(req.first_z);
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= job_in;
    end
  end

  assign job = mem[rd_ptr];

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QP'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/rti_back.sv]
`default_nettype none

module rti_back #(
  parameter int FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire rti_pkg::job_t           job,
  input  wire logic                    job_valid,
  output logic                         pop,
  input  wire logic [rti_pkg::EPS_W-1:0] eps,
  output logic                         rsp_valid,
  input  wire logic                    rsp_ready,
  output rti_pkg::out_item_t           rsp
);
  import rti_pkg::*;

  localparam int L     = MUL_LAT;
  localparam int NS    = 3 * L + 36;
  localparam int PD_W  = SUB_W + CROSS_W;
  localparam int EA_W  = DOT_W + EPS_W + 1;

  logic          en;
  logic [NS-1:0] vld;

  // The whole pipeline advances unless a finished result waits.
  assign en        = !rsp_valid || rsp_ready;
  assign pop       = en && job_valid;
  assign rsp_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], pop};
    end
  end

  // Cross products h = d x e2 and q = s x e1.
  logic signed [CROSS_W-1:0] hp0 [3];
  logic signed [CROSS_W-1:0] hp1 [3];
  logic signed [CROSS_W-1:0] qp0 [3];
  logic signed [CROSS_W-1:0] qp1 [3];

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    rti_mul #(.AW(SUB_W), .BW(SUB_W)) u_h0 (
      .clk(clk), .en(en),
      .a(SUB_W'($signed(job.d[J]))), .b(SUB_W'($signed(job.e2[K]))), .p(hp0[i])
    );
    rti_mul #(.AW(SUB_W), .BW(SUB_W)) u_h1 (
      .clk(clk), .en(en),
      .a(SUB_W'($signed(job.d[K]))), .b(SUB_W'($signed(job.e2[J]))), .p(hp1[i])
    );
    rti_mul #(.AW(SUB_W), .BW(SUB_W)) u_q0 (
      .clk(clk), .en(en),
      .a($signed(job.s[J])), .b(SUB_W'($signed(job.e1[K]))), .p(qp0[i])
    );
    rti_mul #(.AW(SUB_W), .BW(SUB_W)) u_q1 (
      .clk(clk), .en(en),
      .a($signed(job.s[K])), .b(SUB_W'($signed(job.e1[J]))), .p(qp1[i])
    );
  end

  // Vectors wait beside the cross product multipliers.
  job_t job_dl [L+1];

  always_ff @(posedge clk) begin
    if (en) begin
      job_dl[0] <= job;
      for (int k = 1; k <= L; k++) begin
        job_dl[k] <= job_dl[k-1];
      end
    end
  end

  logic signed [CROSS_W-1:0] h [3];
  logic signed [CROSS_W-1:0] q [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        h[i] <= hp0[i] - hp1[i];
        q[i] <= qp0[i] - qp1[i];
      end
    end
  end

  // Dot products a = e1.h, u = s.h, v = d.q, t = e2.q.
  logic signed [PD_W-1:0] pa [3];
  logic signed [PD_W-1:0] pu [3];
  logic signed [PD_W-1:0] pv [3];
  logic signed [PD_W-1:0] pt [3];
  job_t                   jv;

  assign jv = job_dl[L];

  for (genvar i = 0; i < 3; i++) begin : g_dot
    rti_mul #(.AW(SUB_W), .BW(CROSS_W)) u_a (
      .clk(clk), .en(en), .a(SUB_W'($signed(jv.e1[i]))), .b(h[i]), .p(pa[i])
    );
    rti_mul #(.AW(SUB_W), .BW(CROSS_W)) u_u (
      .clk(clk), .en(en), .a($signed(jv.s[i])), .b(h[i]), .p(pu[i])
    );
    rti_mul #(.AW(SUB_W), .BW(CROSS_W)) u_v (
      .clk(clk), .en(en), .a(SUB_W'($signed(jv.d[i]))), .b(q[i]), .p(pv[i])
    );
    rti_mul #(.AW(SUB_W), .BW(CROSS_W)) u_t (
      .clk(clk), .en(en), .a(SUB_W'($signed(jv.e2[i]))), .b(q[i]), .p(pt[i])
    );
  end

  logic signed [DOT_W-1:0] a_s, u_s, v_s, t_s;

  always_ff @(posedge clk) begin
    if (en) begin
      a_s <= DOT_W'(pa[0]) + DOT_W'(pa[1]) + DOT_W'(pa[2]);
      u_s <= DOT_W'(pu[0]) + DOT_W'(pu[1]) + DOT_W'(pu[2]);
      v_s <= DOT_W'(pv[0]) + DOT_W'(pv[1]) + DOT_W'(pv[2]);
      t_s <= DOT_W'(pt[0]) + DOT_W'(pt[1]) + DOT_W'(pt[2]);
    end
  end

  // Make the determinant non-negative, flipping the numerators with it.
  logic signed [DOT_W-1:0] a_n, u_n, v_n, t_n;

  always_ff @(posedge clk) begin
    if (en) begin
      a_n <= a_s[DOT_W-1] ? -a_s : a_s;
      u_n <= a_s[DOT_W-1] ? -u_s : u_s;
      v_n <= a_s[DOT_W-1] ? -v_s : v_s;
      t_n <= a_s[DOT_W-1] ? -t_s : t_s;
    end
  end

  // Epsilon times determinant for the minimum distance test.
  logic signed [EA_W-1:0]      epsa;
  logic        [3:0][DOT_W-1:0] auvt_dl [L];
  logic signed [DOT_W-1:0]      aq, uq, vq, tq;

  rti_mul #(.AW(DOT_W), .BW(EPS_W + 1)) u_eps (
    .clk(clk), .en(en), .a(a_n), .b($signed({1'b0, eps})), .p(epsa)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      auvt_dl[0] <= {a_n, u_n, v_n, t_n};
      for (int k = 1; k < L; k++) begin
        auvt_dl[k] <= auvt_dl[k-1];
      end
    end
  end

  assign aq = $signed(auvt_dl[L-1][3]);
  assign uq = $signed(auvt_dl[L-1][2]);
  assign vq = $signed(auvt_dl[L-1][1]);
  assign tq = $signed(auvt_dl[L-1][0]);

  // Classify the test by cross-multiplied comparisons.
  logic signed [EXT_W-1:0]   a_x, lhs_c, epsa_x, eps_big;
  logic signed [DOT_W:0]     uv;
  reason_t                   reason_c;
  logic                      sat_c;

  always_comb begin
    a_x     = EXT_W'(aq);
    lhs_c   = EXT_W'(tq) <<< FRAC_BITS;
    epsa_x  = EXT_W'(epsa);
    eps_big = $signed(EXT_W'(eps) << (2 * FRAC_BITS));
    uv      = (DOT_W+1)'(uq) + (DOT_W+1)'(vq);
    sat_c   = (lhs_c >= (a_x <<< 31));
    if ((aq == '0) || (a_x < eps_big)) begin
      reason_c = RSN_PARALLEL;
    end else if (uq[DOT_W-1] || (uq > aq)) begin
      reason_c = RSN_U_RANGE;
    end else if (vq[DOT_W-1] || (uv > (DOT_W+1)'(aq))) begin
      reason_c = RSN_V_RANGE;
    end else if (lhs_c <= epsa_x) begin
      reason_c = RSN_BEHIND;
    end else begin
      reason_c = RSN_HIT;
    end
  end

  logic [EXT_W-1:0]  lhs;
  logic [DOT_W-1:0]  den;
  logic [META_W-1:0] meta;

  always_ff @(posedge clk) begin
    if (en) begin
      lhs  <= lhs_c;
      den  <= aq;
      meta <= {reason_c, sat_c};
    end
  end

  // Distance quotient.
  logic [DIST_W-1:0] quo;
  logic [META_W-1:0] meta_q;
  logic              hit_q;

  rti_div #(.NW(EXT_W), .DW(DOT_W), .QW(DIST_W), .MW(META_W)) u_div (
    .clk(clk), .en(en), .num(lhs), .den(den), .meta_in(meta),
    .quo(quo), .meta_out(meta_q)
  );

  assign hit_q = (meta_q[META_W-1:1] == RSN_HIT);

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      rsp.hit         <= hit_q;
      rsp.miss_reason <= meta_q[META_W-1:1];
      if (!hit_q) begin
        rsp.distance <= '0;
      end else if (meta_q[0]) begin
        rsp.distance <= DIST_MAX;
      end else begin
        rsp.distance <= quo;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/ray_triangle_intersect.sv]
// Ray/triangle intersection in signed fixed point.
// The req channel (valid/ready) takes transactions of two kinds. A ray load
// stores origin and direction and returns nothing. A triangle test carries v0,
// e1 and e2 and returns one rsp transaction: hit flag, distance t (truncated,
// saturated at the largest value) and the reason for a miss.
// The cfg port writes the epsilon register in the cycle cfg_we is high; the
// user must write it only while no test is in flight; the block has no guard.
// Throughput is one transaction per cycle while the receiver takes results.
// A test result passes through the input queue, three chained pipelined
// multiplier groups (cross product, dot product, epsilon scale), three
// adder and sign stages, a classify stage, a 31-stage restoring divider
// for t and the output register.
// When the receiver stalls, the back pipeline freezes as a whole; the
// two-entry queue takes further transactions and req_ready then drops.
// Reset clears the stored ray to zero, sets epsilon to one and empties the
// queue and the pipeline; there is no clearing pass.
`default_nettype none

module ray_triangle_intersect #(
  parameter int FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  output logic                           req_ready,
  input  wire rti_pkg::in_item_t         req,
  output logic                           rsp_valid,
  input  wire logic                      rsp_ready,
  output rti_pkg::out_item_t             rsp,
  input  wire logic                      cfg_we,
  input  wire logic [rti_pkg::EPS_W-1:0] cfg_wdata
);
  import rti_pkg::*;

  logic [EPS_W-1:0] eps;
  job_t             job;
  logic             job_valid;
  logic             pop;

  // Epsilon register.
  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPS_RESET;
    end else if (cfg_we) begin
      eps <= cfg_wdata;
    end
  end

  rti_front u_front (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .pop(pop), .job(job), .job_valid(job_valid)
  );

  rti_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .job(job), .job_valid(job_valid), .pop(pop), .eps(eps),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

`ifndef NO_ASSERTIONS
  // A miss never reports a distance and never claims a hit code.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.hit) |-> (rsp.distance == '0 && rsp.miss_reason != RSN_HIT))
    else $error("miss transaction with distance or hit code");

  // A hit always carries the hit code.
  a_hit_code: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.hit) |-> (rsp.miss_reason == RSN_HIT))
    else $error("hit transaction with a miss code");

  // The back end only takes from a queue that holds a test.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> job_valid)
    else $error("queue read while empty");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result pending after reset");
`endif

endmodule

`default_nettype wire
